FILE: hdl/ctag_pkg.sv
// Shared types and codes of the two-way cache tag engine.
package ctag_pkg;

  // Access kinds carried in the operation field.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Lookup outcome flags passed from the policy logic to the pipeline.
  typedef struct packed {
    logic hit;
    logic way;
    logic wb_needed;
  } ctag_flags_t;

endpackage

FILE: hdl/ctag_if.sv
// Valid/ready channel interfaces for cache accesses and lookup results.
interface ctag_req_if #(
  parameter int ADDR_W = 32
);
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output operation, output address, input ready);
  modport sink   (input valid, input operation, input address, output ready);
endinterface

interface ctag_rsp_if #(
  parameter int OFFSET_W = 6,
  parameter int BLOCK_W  = 26
);
  logic                valid;
  logic                ready;
  logic                hit;
  logic                way;
  logic [OFFSET_W-1:0] word_offset;
  logic [BLOCK_W-1:0]  fill_block;
  logic                writeback_needed;
  logic [BLOCK_W-1:0]  writeback_block;

  modport source (output valid, output hit, output way, output word_offset,
                  output fill_block, output writeback_needed, output writeback_block,
                  input ready);
  modport sink   (input valid, input hit, input way, input word_offset,
                  input fill_block, input writeback_needed, input writeback_block,
                  output ready);
endinterface

FILE: hdl/ctag_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ctag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/ctag_policy.sv
// Tag compare, LRU victim choice and set entry update for one access.
module ctag_policy
  import ctag_pkg::*;
#(
  parameter int TAG_BITS = 18,
  parameter int SET_BITS = 8
) (
  input  logic [2*(TAG_BITS+2):0]      entry,
  input  logic                         operation,
  input  logic [TAG_BITS+SET_BITS-1:0] block,
  output logic [2*(TAG_BITS+2):0]      entry_upd,
  output ctag_flags_t                  flags,
  output logic [TAG_BITS+SET_BITS-1:0] fill_block,
  output logic [TAG_BITS+SET_BITS-1:0] wb_block
);

  localparam int WAY_W = TAG_BITS + 2;

  logic [WAY_W-1:0]    way0, way1, sel, sel_upd;
  logic [TAG_BITS-1:0] tag;
  logic [SET_BITS-1:0] set_idx;
  logic                hit0, hit1, hit, way, wb;

  assign tag     = block[TAG_BITS+SET_BITS-1:SET_BITS];
  assign set_idx = block[SET_BITS-1:0];
  assign way0    = entry[WAY_W-1:0];
  assign way1    = entry[2*WAY_W-1:WAY_W];

  // Each way record is {valid, dirty, tag}; way 0 wins if both match.
  assign hit0 = way0[WAY_W-1] && (way0[TAG_BITS-1:0] == tag);
  assign hit1 = way1[WAY_W-1] && (way1[TAG_BITS-1:0] == tag);
  assign hit  = hit0 || hit1;
  assign way  = hit0 ? 1'b0 : (hit1 ? 1'b1 : entry[2*WAY_W]);
  assign sel  = way ? way1 : way0;

  // A miss evicts the selected way; only a valid dirty victim is written back.
  assign wb         = !hit && sel[WAY_W-1] && sel[WAY_W-2];
  assign wb_block   = wb ? {sel[TAG_BITS-1:0], set_idx} : '0;
  assign fill_block = hit ? '0 : block;

  // Refill installs the tag clean; a write then marks the serving way dirty.
  always_comb begin
    sel_upd = hit ? sel : {1'b1, 1'b0, tag};
    if (operation == OP_WRITE) begin
      sel_upd[WAY_W-2] = 1'b1;
    end
  end

  // The other way becomes the next victim of the set.
  always_comb begin
    entry_upd = {~way, way1, way0};
    if (way) begin
      entry_upd[2*WAY_W-1:WAY_W] = sel_upd;
    end else begin
      entry_upd[WAY_W-1:0] = sel_upd;
    end
  end

  assign flags = '{hit: hit, way: way, wb_needed: wb};

endmodule

FILE: hdl/two_way_lru_writeback_cache_tags.sv
// Top level of the two-way set-associative write-back cache tag engine.
//
// Each access transfer yields one result transfer. The block sustains one access per
// clock cycle while the result side takes results as they come: the set memory is read
// at the transfer edge as the access enters the lookup stage, where the compare and
// update are done before the result goes to the output register. All state of a set
// (both tags with their valid and dirty bits and the recency bit) lives in one word of
// a single set memory, read at the access transfer and written back when the lookup
// stage advances; a back-to-back access to the same set takes the freshly updated word
// from a bypass register. After reset the block clears the set memory, one set per
// cycle, and accepts no access until every set is cleared. SETS must be a power of two.
module two_way_lru_writeback_cache_tags
  import ctag_pkg::*;
#(
  parameter int SETS         = 256,
  parameter int OFFSET_BITS  = 6,
  parameter int ADDRESS_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ctag_req_if.sink  in_req,
  ctag_rsp_if.source out_rsp
);

  localparam int SET_BITS   = $clog2(SETS);
  localparam int BLOCK_BITS = ADDRESS_BITS - OFFSET_BITS;
  localparam int TAG_BITS   = BLOCK_BITS - SET_BITS;
  localparam int WAY_W      = TAG_BITS + 2;
  localparam int ENTRY_W    = 2 * WAY_W + 1;
  localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(SETS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SET_BITS-1:0]     clr_idx_r, clr_idx_nxt;
  logic                    b_v_r, b_op_r, fwd_r;
  logic [ADDRESS_BITS-1:0] b_addr_r;
  logic [ENTRY_W-1:0]      fwd_data_r, rd_data, cur_entry, new_entry;
  logic                    out_v_r, out_hit_r, out_way_r, out_wbn_r;
  logic [OFFSET_BITS-1:0]  out_off_r;
  logic [BLOCK_BITS-1:0]   out_fill_r, out_wbb_r;

  logic                    clearing, advance_b, in_xfer;
  logic [SET_BITS-1:0]     in_set, b_set;
  logic [BLOCK_BITS-1:0]   b_block, fill_blk, wb_blk;
  ctag_flags_t             flags;

  assign clearing  = (state_r == ST_CLEAR);
  assign in_set    = in_req.address[OFFSET_BITS +: SET_BITS];
  assign b_block   = b_addr_r[ADDRESS_BITS-1:OFFSET_BITS];
  assign b_set     = b_block[SET_BITS-1:0];

  // The lookup stage moves on when the output register is free or being drained.
  assign advance_b    = b_v_r && (!out_v_r || out_rsp.ready);
  assign in_req.ready = !clearing && (!b_v_r || advance_b);
  assign in_xfer      = in_req.valid && in_req.ready;

  // Clearing pass sequencer.
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_SET) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Set memory: cleared by the clearing pass, read at transfer, written back when the lookup stage advances.
  ctag_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SETS)
  ) u_set_ram (
    .clk  (clk),
    .we   (clearing || advance_b),
    .waddr(clearing ? clr_idx_r : b_set),
    .wdata(clearing ? '0 : new_entry),
    .re   (in_xfer),
    .raddr(in_set),
    .rdata(rd_data)
  );

  // A read that coincided with a write to the same set saw the old word.
  assign cur_entry = fwd_r ? fwd_data_r : rd_data;

  ctag_policy #(
    .TAG_BITS(TAG_BITS),
    .SET_BITS(SET_BITS)
  ) u_policy (
    .entry     (cur_entry),
    .operation (b_op_r),
    .block     (b_block),
    .entry_upd (new_entry),
    .flags     (flags),
    .fill_block(fill_blk),
    .wb_block  (wb_blk)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      b_v_r     <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (in_xfer) begin
        b_v_r <= 1'b1;
      end else if (advance_b) begin
        b_v_r <= 1'b0;
      end
      if (advance_b) begin
        out_v_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Lookup stage payload and the same-set bypass.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_op_r     <= in_req.operation;
      b_addr_r   <= in_req.address;
      fwd_r      <= advance_b && (b_set == in_set);
      fwd_data_r <= new_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance_b) begin
      out_hit_r  <= flags.hit;
      out_way_r  <= flags.way;
      out_wbn_r  <= flags.wb_needed;
      out_off_r  <= b_addr_r[OFFSET_BITS-1:0];
      out_fill_r <= fill_blk;
      out_wbb_r  <= wb_blk;
    end
  end

  assign out_rsp.valid            = out_v_r;
  assign out_rsp.hit              = out_hit_r;
  assign out_rsp.way              = out_way_r;
  assign out_rsp.word_offset      = out_off_r;
  assign out_rsp.fill_block       = out_fill_r;
  assign out_rsp.writeback_needed = out_wbn_r;
  assign out_rsp.writeback_block  = out_wbb_r;

endmodule

FILE: hdl/ctag_checker.sv
// Port-level checks of the cache tag engine and their binding to the top level.
module ctag_checker #(
  parameter int BLOCK_BITS = 26
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_hit,
  input logic [BLOCK_BITS-1:0] out_fill_block,
  input logic                  out_writeback_needed,
  input logic [BLOCK_BITS-1:0] out_writeback_block
);

  // A hit neither fetches nor evicts.
  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_fill_block == '0) && !out_writeback_needed)
    else $error("hit result carries fill or write-back");

  // Without a write-back the victim block number reads zero.
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_writeback_needed |-> out_writeback_block == '0)
    else $error("write-back block set without write-back");

  // An evicted dirty block is never the block being fetched.
  a_wb_differs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_writeback_needed |-> !out_hit && (out_writeback_block != out_fill_block))
    else $error("write-back of the block being fetched");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fill_block)
                               && $stable(out_writeback_block))
    else $error("stalled result changed");

endmodule

bind two_way_lru_writeback_cache_tags ctag_checker #(
  .BLOCK_BITS(BLOCK_BITS)
) u_ctag_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_rsp.valid),
  .out_ready           (out_rsp.ready),
  .out_hit             (out_rsp.hit),
  .out_fill_block      (out_rsp.fill_block),
  .out_writeback_needed(out_rsp.writeback_needed),
  .out_writeback_block (out_rsp.writeback_block)
);
